// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
package bba_pkg;

	// Default geometry: 4 MiB pool, 4 KiB granules
	localparam int unsigned POOL_SIZE_LOG2_DEF    = 22;
	localparam int unsigned GRANULE_SIZE_LOG2_DEF = 12;
	localparam int unsigned MAX_ORDER_DEF         = POOL_SIZE_LOG2_DEF - GRANULE_SIZE_LOG2_DEF;

	// Field widths on the stream ports
	localparam int unsigned REQ_W       = 23;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_OFF_W   = 22;
	localparam int unsigned OUT_ORD_W   = 4;
	localparam int unsigned OUT_TDATA_W = 32;
	localparam int unsigned OUT_TUSER_W = 1;

	// Header bit positions
	localparam int unsigned HDR_ALLOC_BIT = 0;
	localparam int unsigned HDR_LEFT_BIT  = 1;
	localparam int unsigned HDR_ORD_LSB   = 2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_EVAL,
		ST_SPLIT,
		ST_FIN
	} state_t;

endpackage

// ===== sv/buddy_block_allocator_unit.sv =====
// Buddy allocator over a pool of 2^POOL_SIZE_LOG2 bytes cut into granules of
// 2^GRANULE_SIZE_LOG2 bytes. Each input item is a byte count; each result item
// says whether a block was granted (tuser), its byte offset plus one for the
// header byte, and its order. Requests above the pool size minus one fail.
// Headers live in a memory of one entry per granule with one read and one write
// port; one adder and compare walk it, one header per cycle, with a split step
// inserted after each split. An item passes a setup step, one evaluation per
// header visited, one split step per split, and a finish step. Entry 0 is served
// from a flag until first written, so no clearing pass runs after reset. The
// block takes one item at a time; the result waits in an output register while
// the next item is already walking.
module buddy_block_allocator_unit #(
	parameter int unsigned POOL_SIZE_LOG2    = bba_pkg::POOL_SIZE_LOG2_DEF,
	parameter int unsigned GRANULE_SIZE_LOG2 = bba_pkg::GRANULE_SIZE_LOG2_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bba_pkg::IN_TDATA_W-1:0]   s_tdata,  // [22:0] request_bytes
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bba_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [21:0] payload_offset, [25:22] block_order
	output logic [bba_pkg::OUT_TUSER_W-1:0]  m_tuser   // [0] granted
);
	import bba_pkg::*;

	localparam int unsigned MAX_ORDER = POOL_SIZE_LOG2 - GRANULE_SIZE_LOG2;
	localparam int unsigned AW        = MAX_ORDER;
	localparam int unsigned PW        = AW + 1;
	localparam int unsigned ORD_W     = $clog2(MAX_ORDER + 1);
	localparam int unsigned HDR_W     = ORD_W + HDR_ORD_LSB;
	localparam int unsigned DEPTH     = 1 << AW;
	localparam int unsigned OFF_W     = (POOL_SIZE_LOG2 > OUT_OFF_W) ? POOL_SIZE_LOG2 : OUT_OFF_W;
	localparam int unsigned PAD_W     = OUT_TDATA_W - OUT_OFF_W - OUT_ORD_W;

	localparam logic [PW-1:0]    GRANULE_COUNT = {1'b1, {AW{1'b0}}};
	localparam logic [HDR_W-1:0] HDR_RESET     = {ORD_W'(MAX_ORDER), 1'b1, 1'b0};

	// Header memory
	logic [HDR_W-1:0] hdr_mem [DEPTH];

	state_t state_q, state_d;

	logic [REQ_W-1:0] bytes_q;
	logic [ORD_W-1:0] need_q;
	logic [PW-1:0]    pos_q;
	logic [HDR_W-1:0] byp_q;
	logic             use_byp_q;
	logic [HDR_W-1:0] rd_q;
	logic             rd0_q;
	logic             e0_valid_q;

	logic                 res_grant_q;
	logic [OUT_OFF_W-1:0] res_off_q;
	logic [OUT_ORD_W-1:0] res_ord_q;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TUSER_W-1:0] out_user_q;

	logic [ORD_W-1:0] need_calc;
	logic             reject;
	logic [HDR_W-1:0] hdr_cur;
	logic             cur_alloc;
	logic [ORD_W-1:0] cur_ord;
	logic [ORD_W-1:0] half;
	logic [ORD_W-1:0] shamt;
	logic [PW-1:0]    sum;
	logic             sum_done;
	logic             skip;
	logic             exact;
	logic [OFF_W-1:0] off_wide;
	logic [OUT_OFF_W-1:0] grant_off;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [HDR_W-1:0] mem_wdata;
	logic [AW-1:0]    rd_addr;
	logic             out_load;

	// Required order: count of order thresholds the request reaches
	always_comb begin
		need_calc = '0;
		for (int k = 1; k <= int'(MAX_ORDER); k++) begin
			need_calc = need_calc + ORD_W'(|(bytes_q >> (GRANULE_SIZE_LOG2 + k - 1)));
		end
	end

	assign reject = (bytes_q >> POOL_SIZE_LOG2) != '0;

	// Current header: bypass after a split, reset value for untouched entry 0
	always_comb begin
		if (use_byp_q) begin
			hdr_cur = byp_q;
		end else if (rd0_q && !e0_valid_q) begin
			hdr_cur = HDR_RESET;
		end else begin
			hdr_cur = rd_q;
		end
	end

	assign cur_alloc = hdr_cur[HDR_ALLOC_BIT];
	assign cur_ord   = hdr_cur[HDR_W-1:HDR_ORD_LSB];
	assign half      = cur_ord - ORD_W'(1);
	assign skip      = cur_alloc || (cur_ord < need_q);
	assign exact     = cur_ord == need_q;

	// Shared adder: next block start on a skip, buddy address on a split
	assign shamt    = (state_q == ST_SPLIT) ? byp_q[HDR_W-1:HDR_ORD_LSB] : cur_ord;
	assign sum      = pos_q + (PW'(1) << shamt);
	assign sum_done = sum >= GRANULE_COUNT;

	assign off_wide  = OFF_W'(pos_q) << GRANULE_SIZE_LOG2;
	assign grant_off = off_wide[OUT_OFF_W-1:0] + OUT_OFF_W'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_START;
			end
			ST_START: begin
				state_d = reject ? ST_FIN : ST_EVAL;
			end
			ST_EVAL: begin
				priority if (skip) begin
					if (sum_done) state_d = ST_FIN;
				end else if (exact) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				state_d = ST_EVAL;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory port and output load
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[AW-1:0];
		mem_wdata = hdr_cur;
		rd_addr   = sum[AW-1:0];
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_START: begin
				rd_addr = '0;
			end
			ST_EVAL: begin
				if (!skip) begin
					mem_we = 1'b1;
					if (exact) begin
						mem_wdata = hdr_cur | HDR_W'(1 << HDR_ALLOC_BIT);
					end else begin
						mem_wdata = {half, 1'b1, 1'b0};
					end
				end
			end
			ST_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = sum[AW-1:0];
				mem_wdata = {byp_q[HDR_W-1:HDR_ORD_LSB], 1'b0, 1'b0};
			end
			ST_FIN: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	// Header memory port
	always_ff @(posedge clk) begin
		if (mem_we) hdr_mem[mem_waddr] <= mem_wdata;
		rd_q <= hdr_mem[rd_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			e0_valid_q  <= 1'b0;
			use_byp_q   <= 1'b0;
			rd0_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd0_q   <= rd_addr == '0;
			if (mem_we && mem_waddr == '0) e0_valid_q <= 1'b1;
			if (state_q == ST_START) use_byp_q <= 1'b0;
			if (state_q == ST_EVAL) use_byp_q <= !skip && !exact;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers and result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) bytes_q <= s_tdata[REQ_W-1:0];
		if (state_q == ST_START) begin
			need_q      <= need_calc;
			pos_q       <= '0;
			res_grant_q <= 1'b0;
			res_off_q   <= '0;
			res_ord_q   <= '0;
		end
		if (state_q == ST_EVAL) begin
			priority if (skip) begin
				pos_q <= sum;
			end else if (exact) begin
				res_grant_q <= 1'b1;
				res_off_q   <= grant_off;
				res_ord_q   <= OUT_ORD_W'(need_q);
			end else begin
				byp_q <= {half, 1'b1, 1'b0};
			end
		end
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, res_ord_q, res_off_q};
			out_user_q <= OUT_TUSER_W'(res_grant_q);
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ===== sv/bba_checker.sv =====
`include "assert_macros.svh"

module bba_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [bba_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bba_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [bba_pkg::OUT_TUSER_W-1:0]  m_tuser
);
	import bba_pkg::*;

	logic [OUT_ORD_W-1:0] ord_field;
	logic                 in_seen;

	assign ord_field = m_tdata[OUT_OFF_W+OUT_ORD_W-1:OUT_OFF_W];
	assign in_seen   = s_tvalid;

	// Stalled result holds
	`BBA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// One item in flight: not ready right after an accept
	`BBA_ASSERT(a_busy_after_accept, in_seen && s_tready |=> !s_tready, "accepted an item while busy")

	// A failed item carries an all-zero payload
	`BBA_ASSERT(a_fail_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "failed item with nonzero data")

	// A granted item skips the header byte and has an order within the pool
	`BBA_ASSERT(a_grant_shape, m_tvalid && m_tuser[0] |-> m_tdata[0] && ord_field <= OUT_ORD_W'(MAX_ORDER_DEF), "malformed grant")

	// Reset held over a clock edge leaves the block idle with no result
	`BBA_ASSERT_ALWAYS(a_reset_idle, !arst_n ##1 !arst_n |-> s_tready && !m_tvalid, "not idle in reset")

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);
